// ===== rtl/ukfs_pkg.sv =====
package ukfs_pkg;

    // Field widths of the stream transactions
    localparam int CMD_W     = 2;
    localparam int KEY_W     = 31;
    localparam int IO_PAY_W  = 32;
    localparam int STAT_W    = 3;
    localparam int COUNT_W   = 5;

    // Input tdata: cmd, key, payload from bit 0 up, padded to whole bytes
    localparam int IN_USED_W  = CMD_W + KEY_W + IO_PAY_W;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata: status, found_key, found_payload, count, is_empty,
    // head_key, head_payload from bit 0 up, padded to whole bytes
    localparam int OUT_USED_W = STAT_W + KEY_W + IO_PAY_W + COUNT_W + 1
                              + KEY_W + IO_PAY_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // Per-cell control from the queue controller
    typedef struct packed {
        logic shift;   // take the neighbor's record (pop toward head)
        logic load;    // take the incoming record (append at tail)
    } t_cell_ctl;

endpackage

// ===== rtl/ukfs_cell.sv =====
module ukfs_cell #(
    parameter int PAY_W = 32
) (
    input  logic                     i_clk,
    input  ukfs_pkg::t_cell_ctl      i_ctl,
    input  logic                     i_live,
    input  logic [ukfs_pkg::KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0]         i_pay,
    input  logic [ukfs_pkg::KEY_W-1:0] i_nxt_key,
    input  logic [PAY_W-1:0]         i_nxt_pay,
    output logic [ukfs_pkg::KEY_W-1:0] o_key,
    output logic [PAY_W-1:0]         o_pay,
    output logic                     o_match
);
    import ukfs_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;

    // Record storage: shift from the neighbor on pop, load on append
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_nxt_key;
            r_pay <= i_nxt_pay;
        end else if (i_ctl.load) begin
            r_key <= i_key;
            r_pay <= i_pay;
        end
    end

    // Local key compare, only for occupied slots
    assign o_match = i_live && (r_key == i_key);
    assign o_key   = r_key;
    assign o_pay   = r_pay;

endmodule

// ===== rtl/unique_key_fifo_with_search_unit.sv =====
// Latency: the result is registered and appears on the master side in the cycle
//   after its input transaction is accepted.
// Throughput: one transaction per cycle unless the master side holds back a
//   result; every cell compares its own key in parallel for each command.
// Reset (synchronous, active low): the queue becomes empty and no result is
//   pending; stored records are not cleared.
module unique_key_fifo_with_search_unit #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // cmd[1:0], key[32:2], payload[64:33], zero pad
    input  logic [ukfs_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // status[2:0], found_key[33:3], found_payload[65:34], count[70:66],
    // is_empty[71], head_key[102:72], head_payload[134:103], zero pad
    output logic [ukfs_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import ukfs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Input unpacking
    logic [CMD_W-1:0]        w_cmd;
    logic [KEY_W-1:0]        w_key;
    logic [IO_PAY_W-1:0]     w_in_pay;
    logic [PAYLOAD_BITS-1:0] w_pay;

    assign w_cmd    = i_s_tdata[CMD_W-1:0];
    assign w_key    = i_s_tdata[CMD_W +: KEY_W];
    assign w_in_pay = i_s_tdata[CMD_W + KEY_W +: IO_PAY_W];

    // Fit the input payload to the stored width
    for (genvar gb = 0; gb < PAYLOAD_BITS; gb++) begin : g_pay_in
        if (gb < IO_PAY_W) begin : g_bit
            assign w_pay[gb] = w_in_pay[gb];
        end else begin : g_zero
            assign w_pay[gb] = 1'b0;
        end
    end

    // Handshake: the output register decouples the two sides
    logic r_out_valid;
    logic w_exec;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_exec     = i_s_tvalid && o_s_tready;

    // Cell chain
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    t_cell_ctl               w_ctl   [DEPTH];
    logic [KEY_W-1:0]        w_ckey  [DEPTH];
    logic [PAYLOAD_BITS-1:0] w_cpay  [DEPTH];
    logic [DEPTH-1:0]        w_match;
    logic                    w_ins_ok;
    logic                    w_rem_ok;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [KEY_W-1:0]        w_nkey;
        logic [PAYLOAD_BITS-1:0] w_npay;

        if (gi == DEPTH - 1) begin : g_tail
            assign w_nkey = w_ckey[gi];
            assign w_npay = w_cpay[gi];
        end else begin : g_mid
            assign w_nkey = w_ckey[gi+1];
            assign w_npay = w_cpay[gi+1];
        end

        assign w_ctl[gi].shift = w_rem_ok;
        assign w_ctl[gi].load  = w_ins_ok && (r_count == CNT_W'(gi));

        ukfs_cell #(
            .PAY_W (PAYLOAD_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl[gi]),
            .i_live    (CNT_W'(gi) < r_count),
            .i_key     (w_key),
            .i_pay     (w_pay),
            .i_nxt_key (w_nkey),
            .i_nxt_pay (w_npay),
            .o_key     (w_ckey[gi]),
            .o_pay     (w_cpay[gi]),
            .o_match   (w_match[gi])
        );
    end

    // Keys are unique, so at most one cell matches: an OR of masked records
    logic [KEY_W-1:0]        w_sel_key;
    logic [PAYLOAD_BITS-1:0] w_sel_pay;

    always_comb begin
        w_sel_key = '0;
        w_sel_pay = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_key = w_sel_key | ({KEY_W{w_match[i]}} & w_ckey[i]);
            w_sel_pay = w_sel_pay | ({PAYLOAD_BITS{w_match[i]}} & w_cpay[i]);
        end
    end

    logic w_dup;
    logic w_full;
    logic w_empty;

    assign w_dup   = |w_match;
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ins_ok = w_exec && (w_cmd == CMD_INSERT) && !w_dup && !w_full;
    assign w_rem_ok = w_exec && (w_cmd == CMD_REMOVE) && !w_empty;

    // Command decode: status, found record, head after the step
    t_status                 w_status;
    logic [KEY_W-1:0]        w_fkey;
    logic [PAYLOAD_BITS-1:0] w_fpay;
    logic [KEY_W-1:0]        w_hkey;
    logic [PAYLOAD_BITS-1:0] w_hpay;

    always_comb begin
        w_status = ST_DONE;
        w_fkey   = '0;
        w_fpay   = '0;
        n_count  = r_count;
        w_hkey   = w_empty ? '0 : w_ckey[0];
        w_hpay   = w_empty ? '0 : w_cpay[0];
        case (w_cmd)
            CMD_INSERT: begin
                if (w_dup) begin
                    w_status = ST_DUPLICATE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    if (w_empty) begin
                        w_hkey = w_key;
                        w_hpay = w_pay;
                    end
                end
            end
            CMD_REMOVE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_fkey  = w_ckey[0];
                    w_fpay  = w_cpay[0];
                    n_count = r_count - CNT_W'(1);
                    w_hkey  = (r_count > CNT_W'(1)) ? w_ckey[1] : '0;
                    w_hpay  = (r_count > CNT_W'(1)) ? w_cpay[1] : '0;
                end
            end
            CMD_SEARCH: begin
                if (w_dup) begin
                    w_fkey = w_sel_key;
                    w_fpay = w_sel_pay;
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    // Fit stored payloads to the output width
    logic [IO_PAY_W-1:0] w_fpay_o;
    logic [IO_PAY_W-1:0] w_hpay_o;

    for (genvar gb = 0; gb < IO_PAY_W; gb++) begin : g_pay_out
        if (gb < PAYLOAD_BITS) begin : g_bit
            assign w_fpay_o[gb] = w_fpay[gb];
            assign w_hpay_o[gb] = w_hpay[gb];
        end else begin : g_zero
            assign w_fpay_o[gb] = 1'b0;
            assign w_hpay_o[gb] = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_exec) begin
                r_count <= n_count;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    t_status             r_status;
    logic [KEY_W-1:0]    r_fkey;
    logic [IO_PAY_W-1:0] r_fpay;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_is_empty;
    logic [KEY_W-1:0]    r_hkey;
    logic [IO_PAY_W-1:0] r_hpay;

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_status    <= w_status;
            r_fkey      <= w_fkey;
            r_fpay      <= w_fpay_o;
            r_out_count <= COUNT_W'(n_count);
            r_is_empty  <= (n_count == '0);
            r_hkey      <= w_hkey;
            r_hpay      <= w_hpay_o;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, r_hpay, r_hkey, r_is_empty,
                         r_out_count, r_fpay, r_fkey, r_status};

`ifndef SYNTH
    // Keys stay unique, so no two cells ever match the same key
    a_onehot_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matched the key");

    // Fill count never exceeds the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // An accepted insert grows the queue by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance the fill count");

    // A reported empty result agrees with the zero head record
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_is_empty) |-> (r_hkey == '0 && r_out_count == '0))
        else $error("empty result with a head record");
`endif

endmodule
